FILE: sv/spi_nor_flash_command_engine_macros.svh
// assertion macros used by the checker in sfce_checker.sv
`ifndef SPI_NOR_FLASH_COMMAND_ENGINE_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_ENGINE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define SFCE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sfce: invariant violated");

// consequent in the same cycle
`define SFCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfce: implication violated");

// consequent in the next cycle
`define SFCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfce: next-cycle implication violated");

`endif

FILE: sv/sfce_pkg.sv
package sfce_pkg;

    localparam int MEM_BYTES_DEF    = 2097152;
    localparam int SECTOR_BYTES_DEF = 4096;

    localparam int ADDR_W    = 24;
    localparam int SIZE_W    = 25;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 2;
    localparam int ID_COUNT  = 3;

    localparam logic [CFG_W-1:0] FLASH_SIZE_RST = 22'd2097152;
    localparam logic [7:0]       ERASED_BYTE    = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_SECOND  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_THIRD   = 2'd3;

    // opcodes
    localparam logic [7:0] OP_JEDEC = 8'h9F;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;

    // opcode class worked out by the front end
    localparam logic [2:0] K_OTHER = 3'd0;
    localparam logic [2:0] K_JEDEC = 3'd1;
    localparam logic [2:0] K_RDSR  = 3'd2;
    localparam logic [2:0] K_WREN  = 3'd3;
    localparam logic [2:0] K_READ  = 3'd4;
    localparam logic [2:0] K_PP    = 3'd5;
    localparam logic [2:0] K_SE    = 3'd6;

    // command phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_JEDEC = 3'd1;
    localparam logic [2:0] PH_RDSR  = 3'd2;
    localparam logic [2:0] PH_ADDR  = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;
    localparam logic [2:0] PH_WRITE = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       release_cs;
        logic [2:0] kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0]             flash_size;
        logic [ID_COUNT-1:0][7:0]     id_bytes;
    } t_cfg;

endpackage

FILE: sv/sfce_front.sv
module sfce_front
    import sfce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] mosi_byte
    input  logic [0:0]  s_axis_tuser,   // [0] action
    input  logic        i_init_done,
    input  logic        i_pop,
    output logic        o_q_valid,
    output t_item       o_q_item
);

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wp;
    logic [QPTR_W-1:0]  n_rp;
    logic [QCNT_W-1:0]  n_cnt;
    logic [2:0]         w_kind;
    logic               w_push;
    t_item              w_item;

    always_comb begin
        case (s_axis_tdata)
            OP_JEDEC: w_kind = K_JEDEC;
            OP_RDSR:  w_kind = K_RDSR;
            OP_WREN:  w_kind = K_WREN;
            OP_READ:  w_kind = K_READ;
            OP_PP:    w_kind = K_PP;
            OP_SE:    w_kind = K_SE;
            default:  w_kind = K_OTHER;
        endcase
    end

    assign w_item.release_cs = s_axis_tuser[0];
    assign w_item.kind       = w_kind;
    assign w_item.data       = s_axis_tdata;

    assign s_axis_tready = (r_cnt != QCNT_W'(QUEUE_DEPTH)) && i_init_done;
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != '0);
    assign o_q_item      = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = r_wp + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + QPTR_W'(1);
        end
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

FILE: sv/sfce_back.sv
module sfce_back
    import sfce_pkg::*;
#(
    parameter int MEM_BYTES    = MEM_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_init_done,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] miso_byte
);

    localparam int                AW        = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] SECT_MASK = ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [SIZE_W-1:0] MEM_SZ    = SIZE_W'(MEM_BYTES);
    localparam logic [SIZE_W-1:0] SECT_SZ   = SIZE_W'(SECTOR_BYTES);
    localparam logic [AW-1:0]     MEM_LAST  = AW'(MEM_BYTES - 1);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_ERASE  = 2'd3;

    logic [7:0]         r_mem [MEM_BYTES];
    logic [7:0]         r_rdata;

    logic [1:0]         r_st,      n_st;
    logic [2:0]         r_phase,   n_phase;
    logic [2:0]         r_kind,    n_kind;
    logic [ADDR_W-1:0]  r_addr,    n_addr;
    logic [1:0]         r_seen,    n_seen;
    logic [1:0]         r_idx,     n_idx;
    logic               r_wel,     n_wel;
    logic               r_busy,    n_busy;
    logic [AW-1:0]      r_sw_addr, n_sw_addr;
    logic [AW-1:0]      r_sw_last, n_sw_last;
    logic               r_ovalid,  n_ovalid;
    logic [7:0]         r_odata,   n_odata;

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [7:0]         w_mem_wdata;
    logic               w_mem_re;
    logic [SIZE_W-1:0]  w_size;
    logic [SIZE_W-1:0]  w_fsize;
    logic [ADDR_W-1:0]  w_base;
    logic [SIZE_W-1:0]  w_base_ext;
    logic [SIZE_W-1:0]  w_sect_end;
    logic [SIZE_W-1:0]  w_erase_last;
    logic [ADDR_W-1:0]  w_addr_inc;
    logic               w_in_range;
    logic               w_out_free;
    logic [7:0]         w_id_byte;

    assign w_fsize      = {{(SIZE_W - CFG_W){1'b0}}, i_cfg.flash_size};
    assign w_size       = (w_fsize > MEM_SZ) ? MEM_SZ : w_fsize;
    assign w_base       = r_addr & ~SECT_MASK;
    assign w_base_ext   = {1'b0, w_base};
    assign w_sect_end   = w_base_ext + SECT_SZ;
    assign w_erase_last = ((w_sect_end > w_size) ? w_size : w_sect_end) - SIZE_W'(1);
    assign w_addr_inc   = r_addr + ADDR_W'(1);
    assign w_in_range   = {1'b0, r_addr} < w_size;
    assign w_out_free   = !r_ovalid || m_axis_tready;
    assign w_id_byte    = (r_idx < 2'(ID_COUNT)) ? i_cfg.id_bytes[r_idx] : 8'h00;

    assign o_q_pop       = (r_st == S_RUN) && i_q_valid && w_out_free;
    assign o_init_done   = (r_st != S_CLEAR);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_st        = r_st;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_seen      = r_seen;
        n_idx       = r_idx;
        n_wel       = r_wel;
        n_busy      = r_busy;
        n_sw_addr   = r_sw_addr;
        n_sw_last   = r_sw_last;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_odata     = r_odata;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_sw_addr;
        w_mem_wdata = ERASED_BYTE;
        w_mem_re    = 1'b0;

        case (r_st)
            S_CLEAR, S_ERASE: begin
                w_mem_we = 1'b1;
                if (r_sw_addr == r_sw_last) begin
                    n_st = S_RUN;
                end else begin
                    n_sw_addr = r_sw_addr + AW'(1);
                end
            end
            S_RDWAIT: begin
                n_ovalid = 1'b1;
                n_odata  = r_rdata;
                n_st     = S_RUN;
            end
            S_RUN: begin
                if (o_q_pop) begin
                    n_ovalid = 1'b1;
                    n_odata  = 8'h00;
                    if (i_q_item.release_cs) begin
                        if (r_wel && r_kind == K_SE) begin
                            if (w_base_ext < w_size) begin
                                n_sw_addr = w_base[AW-1:0];
                                n_sw_last = w_erase_last[AW-1:0];
                                n_st      = S_ERASE;
                            end
                            n_wel = 1'b0;
                        end
                        if (r_wel && r_kind == K_PP) begin
                            n_wel = 1'b0;
                        end
                        n_phase = PH_IDLE;
                        n_kind  = K_OTHER;
                        n_addr  = '0;
                        n_seen  = '0;
                        n_idx   = '0;
                        n_busy  = 1'b0;
                    end else begin
                        case (r_phase)
                            PH_IDLE: begin
                                n_kind = i_q_item.kind;
                                n_addr = '0;
                                n_seen = '0;
                                n_idx  = '0;
                                case (i_q_item.kind)
                                    K_JEDEC:            n_phase = PH_JEDEC;
                                    K_RDSR:             n_phase = PH_RDSR;
                                    K_WREN:             n_wel   = 1'b1;
                                    K_READ, K_PP, K_SE: n_phase = PH_ADDR;
                                    default:            n_phase = PH_IDLE;
                                endcase
                            end
                            PH_JEDEC: begin
                                n_odata = w_id_byte;
                                n_idx   = r_idx + 2'd1;
                                if (r_idx == 2'(ID_COUNT - 1)) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_RDSR: begin
                                n_odata = {7'd0, r_busy};
                            end
                            PH_ADDR: begin
                                n_addr = {r_addr[ADDR_W-9:0], i_q_item.data};
                                n_seen = r_seen + 2'd1;
                                if (r_seen == 2'd2) begin
                                    if (r_kind == K_READ) begin
                                        n_phase = PH_READ;
                                        n_idx   = '0;
                                    end else if (r_kind == K_PP) begin
                                        n_phase = PH_WRITE;
                                        n_idx   = '0;
                                        n_busy  = 1'b1;
                                    end else begin
                                        n_busy  = 1'b1;
                                        n_phase = PH_IDLE;
                                    end
                                end
                            end
                            PH_READ: begin
                                if (w_in_range) begin
                                    w_mem_re = 1'b1;
                                    n_ovalid = 1'b0;
                                    n_st     = S_RDWAIT;
                                end else begin
                                    n_odata = ERASED_BYTE;
                                end
                                if ({1'b0, w_addr_inc} >= w_size) begin
                                    n_addr = '0;
                                end else begin
                                    n_addr = w_addr_inc;
                                end
                            end
                            PH_WRITE: begin
                                if (r_wel && w_in_range) begin
                                    w_mem_we    = 1'b1;
                                    w_mem_waddr = r_addr[AW-1:0];
                                    w_mem_wdata = i_q_item.data;
                                end
                                n_addr = w_addr_inc;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_st = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_CLEAR;
            r_phase   <= PH_IDLE;
            r_kind    <= K_OTHER;
            r_addr    <= '0;
            r_seen    <= '0;
            r_idx     <= '0;
            r_wel     <= 1'b0;
            r_busy    <= 1'b0;
            r_sw_addr <= '0;
            r_sw_last <= MEM_LAST;
            r_ovalid  <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_addr    <= n_addr;
            r_seen    <= n_seen;
            r_idx     <= n_idx;
            r_wel     <= n_wel;
            r_busy    <= n_busy;
            r_sw_addr <= n_sw_addr;
            r_sw_last <= n_sw_last;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    // single-port byte array, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

endmodule

FILE: sv/spi_nor_flash_command_engine.sv
// channel   | dir | transfer payload                     | side fields
// s_axis    | in  | tdata[7:0] mosi_byte                 | tuser[0] action (1 = cs release)
// m_axis    | out | tdata[7:0] miso_byte                 | none
// cfg write | in  | i_cfg_idx register, i_cfg_data value | i_cfg_we strobe
//
// a byte transfer passes the four-entry queue and the back end, which goes through
// S_RDWAIT when the byte array is read
// a release with a pending sector erase holds the back end while the single array
// port writes 0xff to up to SECTOR_BYTES bytes; the queue still takes transfers
// after reset all MEM_BYTES bytes of the array are cleared with s_axis_tready low
// a stalled m_axis holds its byte while the queue keeps filling
module spi_nor_flash_command_engine
    import sfce_pkg::*;
#(
    parameter int MEM_BYTES    = MEM_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] mosi_byte
    input  logic [0:0]            s_axis_tuser,   // [0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] miso_byte
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    logic   w_init_done;
    logic   w_pop;
    logic   w_q_valid;
    t_item  w_q_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FLASH_SIZE: n_cfg.flash_size  = i_cfg_data;
                REG_ID_FIRST:   n_cfg.id_bytes[0] = i_cfg_data[7:0];
                REG_ID_SECOND:  n_cfg.id_bytes[1] = i_cfg_data[7:0];
                REG_ID_THIRD:   n_cfg.id_bytes[2] = i_cfg_data[7:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_size <= FLASH_SIZE_RST;
            r_cfg.id_bytes   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sfce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_init_done   (w_init_done),
        .i_pop         (w_pop),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item)
    );

    sfce_back #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_pop),
        .o_init_done   (w_init_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: sv/sfce_checker.sv
`include "spi_nor_flash_command_engine_macros.svh"

module sfce_checker
    import sfce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  s_axis_tvalid,
    input  logic  s_axis_tready,
    input  logic  m_axis_tvalid,
    input  logic  m_axis_tready
);

    localparam logic [3:0] PEND_MAX = 4'(QUEUE_DEPTH + 2);

    logic [3:0] r_pend;
    logic [3:0] n_pend;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_pend = r_pend;
        if (w_in_xfer && !w_out_xfer) begin
            n_pend = r_pend + 4'd1;
        end else if (!w_in_xfer && w_out_xfer) begin
            n_pend = r_pend - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // items in flight stay within queue, read stage and output register
    `SFCE_ASSERT_ALWAYS(a_pend_bound, r_pend <= PEND_MAX)

    // every result belongs to an earlier input transfer
    `SFCE_ASSERT_IMPL(a_out_has_source, m_axis_tvalid, r_pend != 4'd0)

    // array clear keeps the input closed straight after reset
    `SFCE_ASSERT_IMPL(a_closed_after_reset, $past(!i_rst_n), !s_axis_tready)

    `SFCE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind spi_nor_flash_command_engine sfce_checker u_sfce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

FILE: test/sfce_miso_checker.sv
`timescale 1ns / 1ps

module sfce_miso_checker
    import sfce_pkg::*;
#(
    parameter int MEM_BYTES    = MEM_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] mosi_byte
    input  logic [0:0]           i_s_tuser,   // [0] action
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [7:0]           i_m_tdata,   // [7:0] miso_byte
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    logic [CFG_W-1:0]  size_reg;
    logic [7:0]        id_reg [ID_COUNT];
    logic [2:0]        cmd_phase;
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        addr_count;
    logic [1:0]        id_count;
    logic              wel;
    logic              busy;
    logic [7:0]        mem [MEM_BYTES];
    logic [7:0]        miso_expected [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report(input string msg);
        $display("miso mismatch at %0t: %s", $realtime, msg);
        o_mismatches++;
    endtask

    function automatic int unsigned usable_size();
        return (size_reg > MEM_BYTES) ? MEM_BYTES : int'(size_reg);
    endfunction

    // chip select release, sector erase happens here
    function automatic void end_of_select();
        int unsigned lim;
        int unsigned base;
        int unsigned stop;
        lim = usable_size();
        if (wel && opcode == OP_SE) begin
            base = int'(addr) & ~(SECTOR_BYTES - 1);
            if (base < lim) begin
                stop = base + SECTOR_BYTES;
                if (stop > lim) begin
                    stop = lim;
                end
                for (int unsigned a = base; a < stop; a++) begin
                    mem[a] = ERASED_BYTE;
                end
            end
            wel = 1'b0;
        end
        if (wel && opcode == OP_PP) begin
            wel = 1'b0;
        end
        cmd_phase  = PH_IDLE;
        opcode     = 8'h00;
        addr       = '0;
        addr_count = '0;
        id_count   = '0;
        busy       = 1'b0;
    endfunction

    function automatic logic [7:0] miso_for_byte(input logic [7:0] mosi);
        logic [7:0]  rx;
        int unsigned lim;
        rx  = 8'h00;
        lim = usable_size();
        case (cmd_phase)
            PH_IDLE: begin
                opcode     = mosi;
                addr       = '0;
                addr_count = '0;
                id_count   = '0;
                if (mosi == OP_JEDEC) begin
                    cmd_phase = PH_JEDEC;
                end else if (mosi == OP_RDSR) begin
                    cmd_phase = PH_RDSR;
                end else if (mosi == OP_WREN) begin
                    wel = 1'b1;
                end else if (mosi == OP_READ || mosi == OP_PP || mosi == OP_SE) begin
                    cmd_phase = PH_ADDR;
                end
            end
            PH_JEDEC: begin
                rx       = (id_count < ID_COUNT) ? id_reg[id_count] : 8'h00;
                id_count = id_count + 2'd1;
                if (id_count >= ID_COUNT) begin
                    cmd_phase = PH_IDLE;
                end
            end
            PH_RDSR: begin
                rx = {7'b0, busy};
            end
            PH_ADDR: begin
                addr       = {addr[15:0], mosi};
                addr_count = addr_count + 2'd1;
                if (addr_count >= 3) begin
                    if (opcode == OP_READ) begin
                        cmd_phase = PH_READ;
                        id_count  = '0;
                    end else if (opcode == OP_PP) begin
                        cmd_phase = PH_WRITE;
                        id_count  = '0;
                        busy      = 1'b1;
                    end else begin
                        busy      = 1'b1;
                        cmd_phase = PH_IDLE;
                    end
                end
            end
            PH_READ: begin
                rx   = (addr < lim) ? mem[addr] : ERASED_BYTE;
                addr = addr + 1'b1;
                if (addr >= lim) begin
                    addr = '0;
                end
            end
            PH_WRITE: begin
                if (wel && addr < lim) begin
                    mem[addr] = mosi;
                end
                addr     = addr + 1'b1;
                id_count = id_count + 2'd1;
            end
            default: begin
                cmd_phase = PH_IDLE;
            end
        endcase
        return rx;
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            size_reg   = FLASH_SIZE_RST;
            for (int i = 0; i < ID_COUNT; i++) begin
                id_reg[i] = 8'h00;
            end
            cmd_phase  = PH_IDLE;
            opcode     = 8'h00;
            addr       = '0;
            addr_count = '0;
            id_count   = '0;
            wel        = 1'b0;
            busy       = 1'b0;
            for (int i = 0; i < MEM_BYTES; i++) begin
                mem[i] = ERASED_BYTE;
            end
            miso_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLASH_SIZE: size_reg  = i_cfg_data;
                    REG_ID_FIRST:   id_reg[0] = i_cfg_data[7:0];
                    REG_ID_SECOND:  id_reg[1] = i_cfg_data[7:0];
                    REG_ID_THIRD:   id_reg[2] = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (miso_expected.size() == 0) begin
                    report($sformatf("unexpected transfer, miso %02h", i_m_tdata));
                end else begin
                    want = miso_expected.pop_front();
                    if (i_m_tdata !== want) begin
                        report($sformatf("miso %02h, want %02h", i_m_tdata, want));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) begin
                    end_of_select();
                    miso_expected.push_back(8'h00);
                end else begin
                    miso_expected.push_back(miso_for_byte(i_s_tdata));
                end
            end
        end
        o_outstanding <= miso_expected.size();
    end

endmodule

FILE: test/spi_nor_flash_command_engine_test.sv
`timescale 1ns / 1ps

module spi_nor_flash_command_engine_test;
    import sfce_pkg::*;

    localparam int MEM_BYTES    = 16384;
    localparam int SECTOR_BYTES = 4096;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int CHOKE_CYCLES = 400;
    localparam int PHASE_ITEMS  = 160;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;
    logic [0:0]           s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    int          mismatches;
    int          outstanding;
    int          items_sent  = 0;
    int unsigned size_lim    = MEM_BYTES;
    bit          steady      = 1'b0;
    bit          choke_req   = 1'b0;
    bit          choke_done  = 1'b0;

    spi_nor_flash_command_engine #(
        .MEM_BYTES   (MEM_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    sfce_miso_checker #(
        .MEM_BYTES   (MEM_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_miso_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("spi_nor_flash_command_engine_test failed");
        $finish;
    end

    // miso sink, with one long hold-off so the input queue backs up
    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (choke_req && !choke_done) begin
                m_axis_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
                choke_done = 1'b1;
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic xfer(input logic rel, input logic [7:0] mosi);
        if (!steady && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mosi;
        s_axis_tuser  <= rel;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] flash_bytes,
                                 input logic [7:0] id0, id1, id2);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FLASH_SIZE;
        i_cfg_data <= flash_bytes;
        @(posedge i_clk);
        i_cfg_idx  <= REG_ID_FIRST;
        i_cfg_data <= CFG_W'(id0);
        @(posedge i_clk);
        i_cfg_idx  <= REG_ID_SECOND;
        i_cfg_data <= CFG_W'(id1);
        @(posedge i_clk);
        i_cfg_idx  <= REG_ID_THIRD;
        i_cfg_data <= CFG_W'(id2);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_lim = (flash_bytes > MEM_BYTES) ? MEM_BYTES : int'(flash_bytes);
    endtask

    // wait for every miso byte, then for a whole sector erase
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SECTOR_BYTES + 16) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 24'($urandom_range(0, 2047));
        if (r == 6) return 24'(size_lim - $urandom_range(0, 6));
        if (r == 7) return 24'($urandom_range(0, MEM_BYTES - 1));
        if (r == 8) return 24'($urandom);
        return 24'hFFFFFF - 24'($urandom_range(0, 3));
    endfunction

    task automatic send_address(input logic [23:0] a, input int unsigned count);
        if (count > 0) xfer(1'b0, a[23:16]);
        if (count > 1) xfer(1'b0, a[15:8]);
        if (count > 2) xfer(1'b0, a[7:0]);
    endtask

    task automatic random_command();
        int unsigned pick;
        logic [23:0] a;
        pick = $urandom_range(0, 99);
        a    = pick_address();
        if (pick < 8) begin
            xfer(1'b0, OP_JEDEC);
            repeat ($urandom_range(1, 4)) xfer(1'b0, 8'($urandom));
            xfer(1'b1, 8'($urandom));
        end else if (pick < 14) begin
            xfer(1'b0, OP_RDSR);
            repeat ($urandom_range(1, 3)) xfer(1'b0, 8'($urandom));
            xfer(1'b1, 8'($urandom));
        end else if (pick < 20) begin
            xfer(1'b0, OP_WREN);
            xfer(1'b1, 8'($urandom));
        end else if (pick < 45) begin
            xfer(1'b0, OP_READ);
            send_address(a, 3);
            repeat ($urandom_range(1, 8)) xfer(1'b0, 8'($urandom));
            xfer(1'b1, 8'($urandom));
        end else if (pick < 70) begin
            if ($urandom_range(0, 3) != 0) begin
                xfer(1'b0, OP_WREN);
                xfer(1'b1, 8'($urandom));
            end
            xfer(1'b0, OP_PP);
            send_address(a, 3);
            repeat ($urandom_range(1, 8)) xfer(1'b0, 8'($urandom));
            xfer(1'b1, 8'($urandom));
        end else if (pick < 80) begin
            if ($urandom_range(0, 3) != 0) begin
                xfer(1'b0, OP_WREN);
                xfer(1'b1, 8'($urandom));
            end
            xfer(1'b0, OP_SE);
            if ($urandom_range(0, 9) < 8) begin
                send_address(a, 3);
                if ($urandom_range(0, 1) == 0) begin
                    xfer(1'b0, OP_RDSR);
                    xfer(1'b0, 8'($urandom));
                end
            end else begin
                send_address(a, $urandom_range(0, 2));
            end
            xfer(1'b1, 8'($urandom));
        end else if (pick < 90) begin
            xfer(1'b0, 8'($urandom));
            repeat ($urandom_range(0, 3)) xfer(1'b0, 8'($urandom));
            xfer(1'b1, 8'($urandom));
        end else begin
            xfer(1'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase_end;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_settings(22'h3FFFFF, 8'h00, 8'hFF, 8'h5A);

        // idle release, id bytes then a new command straight after them
        xfer(1'b1, 8'hFF);
        xfer(1'b0, OP_JEDEC);
        xfer(1'b0, 8'h00);
        xfer(1'b0, 8'hFF);
        xfer(1'b0, 8'hA5);
        xfer(1'b0, OP_WREN);
        xfer(1'b1, 8'h00);
        // program two bytes at 0x10, then read from 0x0f over the first of them
        xfer(1'b0, OP_PP);
        send_address(24'h000010, 3);
        xfer(1'b0, 8'h00);
        xfer(1'b0, 8'hFF);
        xfer(1'b1, 8'h00);
        xfer(1'b0, OP_READ);
        send_address(24'h00000F, 3);
        xfer(1'b0, 8'h00);
        xfer(1'b0, 8'hFF);
        xfer(1'b1, 8'h00);
        // erase with busy read back before release
        xfer(1'b0, OP_WREN);
        xfer(1'b1, 8'h00);
        xfer(1'b0, OP_SE);
        send_address(24'h000010, 3);
        xfer(1'b0, OP_RDSR);
        xfer(1'b0, 8'h00);
        xfer(1'b1, 8'h00);

        phase_end = items_sent;
        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: load_settings(CFG_W'(SECTOR_BYTES), 8'hFF, 8'h00, 8'($urandom));
                    2: load_settings('0, 8'($urandom), 8'($urandom), 8'hFF);
                    3: load_settings(22'd10000, 8'($urandom), 8'h00, 8'($urandom));
                    default: load_settings(CFG_W'(MEM_BYTES), 8'($urandom), 8'($urandom),
                                           8'($urandom));
                endcase
            end
            steady    = (p == 1);
            choke_req = choke_req || (p == 1);
            phase_end = phase_end + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                random_command();
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("spi_nor_flash_command_engine_test passed");
        end else begin
            $display("spi_nor_flash_command_engine_test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/sfce_pkg.sv
sv/sfce_front.sv
sv/sfce_back.sv
sv/spi_nor_flash_command_engine.sv
sv/sfce_checker.sv
test/sfce_miso_checker.sv
test/spi_nor_flash_command_engine_test.sv
